/* rtl/core/interface_definition_tokenizer_unit_assert.svh */
// Assertion macros for the tokenizer unit.
// Used by the top level only; bodies vanish when SYNTH is defined.
`ifndef INTERFACE_DEFINITION_TOKENIZER_UNIT_ASSERT_SVH
`define INTERFACE_DEFINITION_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define IDT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IDT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define IDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/idt_pkg.sv */
// Package for the tokenizer unit: payload structs, token kinds, scan modes.
// No dependencies; imported by every module of the block.
package idt_pkg;
   localparam int LineWidthDefault   = 20;
   localparam int ColumnWidthDefault = 16;
   localparam int OffsetWidthDefault = 24;
   localparam int LenWidth           = 24;
   localparam logic [3:0] TabWidthReset = 4'd4;

   typedef enum logic [2:0] {
      KIND_PUNCT   = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_INTEGER = 3'd2,
      KIND_STRING  = 3'd3,
      KIND_END     = 3'd4,
      KIND_BAD     = 3'd5,
      KIND_OPEN_CM = 3'd6,
      KIND_OPEN_ST = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR,
      MODE_IDENT, MODE_ZERO, MODE_INTEGER, MODE_STRING, MODE_ERROR
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [19:0] start_line;
      logic [15:0] start_column;
      logic [23:0] start_offset;
      logic [23:0] token_length;
      logic [7:0]  char_value;
      logic        last_of_run;
   } rsp_type;

   // Up to two results produced by one input item.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } pair_type;

   function automatic logic is_punct(input logic [7:0] b);
      return b inside {8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3C, 8'h3E,
                       8'h2A, 8'h2C, 8'h3B, 8'h3D};
   endfunction
   function automatic logic is_alpha(input logic [7:0] b);
      return (b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]});
   endfunction
   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction
   function automatic logic is_word(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || (b == 8'h5F);
   endfunction
endpackage

/* rtl/core/idt_front.sv */
// Front part: scanner state machine and position counters, one byte a cycle on step.
// Depends on idt_pkg; feeds result pairs into idt_queue.
module idt_front import idt_pkg::*; #(
   parameter int LINE_WIDTH   = LineWidthDefault,
   parameter int COLUMN_WIDTH = ColumnWidthDefault,
   parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  item,
   input  logic [3:0] tab_width,
   output logic     push,
   output pair_type pair
);
   mode_type mode_ff, mode_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in, sline_ff, sline_in;
   logic [COLUMN_WIDTH-1:0] col_ff, col_in, scol_ff, scol_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in, soff_ff, soff_in;
   logic [LenWidth-1:0]     len_ff, len_in, len_inc;
   logic [COLUMN_WIDTH:0]   col_sum;

   rsp_type res [2];
   logic [1:0] cnt;
   logic [7:0] b;

   localparam logic [LINE_WIDTH-1:0]   LineMax = '1;
   localparam logic [COLUMN_WIDTH-1:0] ColMax  = '1;
   localparam logic [OFFSET_WIDTH-1:0] OffMax  = '1;

   function automatic rsp_type mk(input kind_type k, input logic [LINE_WIDTH-1:0] l,
                                  input logic [COLUMN_WIDTH-1:0] c,
                                  input logic [OFFSET_WIDTH-1:0] o,
                                  input logic [LenWidth-1:0] n, input logic [7:0] ch);
      rsp_type r;
      r.token_kind   = k;
      r.start_line   = 20'(l);
      r.start_column = 16'(c);
      r.start_offset = 24'(o);
      r.token_length = n;
      r.char_value   = ch;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // Mode transition and result generation.
   always_comb begin
      logic rehandle;
      b = item.in_byte;
      mode_in = mode_ff;
      sline_in = sline_ff; scol_in = scol_ff; soff_in = soff_ff; len_in = len_ff;
      len_inc = (len_ff == '1) ? len_ff : len_ff + 1'b1;
      res[0] = '0; res[1] = '0; cnt = 2'd0; rehandle = 1'b0;
      line_in = line_ff; col_in = col_ff; off_in = off_ff;
      col_sum = '0;
      if (item.end_of_input) begin
         case (mode_ff)
            MODE_SLASH: begin
               res[0] = mk(KIND_BAD, sline_ff, scol_ff, soff_ff, len_ff, 8'h2F); cnt = 2'd1;
            end
            MODE_BLOCK, MODE_BLOCK_STAR: begin
               res[0] = mk(KIND_OPEN_CM, sline_ff, scol_ff, soff_ff, len_ff, 8'h00); cnt = 2'd1;
            end
            MODE_IDENT: begin
               res[0] = mk(KIND_IDENT, sline_ff, scol_ff, soff_ff, len_ff, 8'h00); cnt = 2'd1;
            end
            MODE_ZERO, MODE_INTEGER: begin
               res[0] = mk(KIND_INTEGER, sline_ff, scol_ff, soff_ff, len_ff, 8'h00); cnt = 2'd1;
            end
            MODE_STRING: begin
               res[0] = mk(KIND_OPEN_ST, sline_ff, scol_ff, soff_ff, len_ff, 8'h00); cnt = 2'd1;
            end
            default: ;
         endcase
         res[cnt[0]] = mk(KIND_END, line_ff, col_ff, off_ff, '0, 8'h00);
         cnt = cnt + 2'd1;
         mode_in = MODE_IDLE;
         line_in = LINE_WIDTH'(1); col_in = COLUMN_WIDTH'(1); off_in = '0;
         sline_in = LINE_WIDTH'(1); scol_in = COLUMN_WIDTH'(1); soff_in = '0; len_in = '0;
      end else begin
         case (mode_ff)
            MODE_SLASH:
               if (b == 8'h2F) mode_in = MODE_LINE;
               else if (b == 8'h2A) begin
                  len_in = len_inc; mode_in = MODE_BLOCK;
               end else begin
                  res[0] = mk(KIND_BAD, sline_ff, scol_ff, soff_ff, len_ff, 8'h2F);
                  cnt = 2'd1; mode_in = MODE_ERROR;
               end
            MODE_LINE: if (b == 8'h0A) mode_in = MODE_IDLE;
            MODE_BLOCK: begin
               len_in = len_inc;
               if (b == 8'h2A) mode_in = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               len_in = len_inc;
               if (b == 8'h2F) mode_in = MODE_IDLE;
               else if (b != 8'h2A) mode_in = MODE_BLOCK;
            end
            MODE_IDENT:
               if (is_word(b)) len_in = len_inc;
               else begin
                  res[0] = mk(KIND_IDENT, sline_ff, scol_ff, soff_ff, len_ff, 8'h00);
                  cnt = 2'd1; rehandle = 1'b1;
               end
            MODE_ZERO:
               if (b == 8'h78 || b == 8'h58) begin
                  len_in = len_inc; mode_in = MODE_IDENT;
               end else if (is_digit(b)) begin
                  len_in = len_inc; mode_in = MODE_INTEGER;
               end else begin
                  res[0] = mk(KIND_INTEGER, sline_ff, scol_ff, soff_ff, len_ff, 8'h00);
                  cnt = 2'd1; rehandle = 1'b1;
               end
            MODE_INTEGER:
               if (is_digit(b)) len_in = len_inc;
               else begin
                  res[0] = mk(KIND_INTEGER, sline_ff, scol_ff, soff_ff, len_ff, 8'h00);
                  cnt = 2'd1; rehandle = 1'b1;
               end
            MODE_STRING:
               if (b == 8'h22) begin
                  res[0] = mk(KIND_STRING, sline_ff, scol_ff, soff_ff, len_inc, 8'h00);
                  cnt = 2'd1; len_in = len_inc; mode_in = MODE_IDLE;
               end else if (b == 8'h0A) begin
                  res[0] = mk(KIND_OPEN_ST, sline_ff, scol_ff, soff_ff, len_ff, 8'h00);
                  cnt = 2'd1; mode_in = MODE_ERROR;
               end else len_in = len_inc;
            MODE_ERROR: ;
            default: rehandle = 1'b1;
         endcase
         // Byte handled afresh between tokens.
         if (rehandle) begin
            if (b inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h08, 8'h0B}) mode_in = MODE_IDLE;
            else if (is_punct(b)) begin
               res[cnt[0]] = mk(KIND_PUNCT, line_ff, col_ff, off_ff, LenWidth'(1), b);
               cnt = cnt + 2'd1; mode_in = MODE_IDLE;
            end else if (b == 8'h2F || is_alpha(b) || b == 8'h5F || is_digit(b) ||
                         b == 8'h22) begin
               sline_in = line_ff; scol_in = col_ff; soff_in = off_ff;
               len_in = LenWidth'(1);
               if (b == 8'h2F) mode_in = MODE_SLASH;
               else if (b == 8'h30) mode_in = MODE_ZERO;
               else if (is_digit(b)) mode_in = MODE_INTEGER;
               else if (b == 8'h22) mode_in = MODE_STRING;
               else mode_in = MODE_IDENT;
            end else begin
               res[cnt[0]] = mk(KIND_BAD, line_ff, col_ff, off_ff, LenWidth'(1), b);
               cnt = cnt + 2'd1; mode_in = MODE_ERROR;
            end
         end
         // Position advance after the byte.
         if (b == 8'h0A) begin
            line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
            col_in = COLUMN_WIDTH'(1);
         end else begin
            if (b == 8'h09) col_sum = {1'b0, col_ff} + (COLUMN_WIDTH+1)'(tab_width);
            else if (b == 8'h0D || b == 8'h08 || b == 8'h0B) col_sum = {1'b0, col_ff};
            else col_sum = {1'b0, col_ff} + 1'b1;
            col_in = col_sum[COLUMN_WIDTH] ? ColMax : col_sum[COLUMN_WIDTH-1:0];
         end
         off_in = (off_ff == OffMax) ? off_ff : off_ff + 1'b1;
      end
      if (cnt == 2'd1) res[0].last_of_run = 1'b1;
      if (cnt == 2'd2) res[1].last_of_run = 1'b1;
      push = step && (cnt != 2'd0);
      pair.two = (cnt == 2'd2);
      pair.first = res[0];
      pair.second = res[1];
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LINE_WIDTH'(1); col_ff <= COLUMN_WIDTH'(1); off_ff <= '0;
         sline_ff <= LINE_WIDTH'(1); scol_ff <= COLUMN_WIDTH'(1); soff_ff <= '0;
         len_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         line_ff <= line_in; col_ff <= col_in; off_ff <= off_in;
         sline_ff <= sline_in; scol_ff <= scol_in; soff_ff <= soff_in;
         len_ff <= len_in;
      end
   end
endmodule

/* rtl/core/idt_queue.sv */
// Queue of result pairs between front and back, four entries deep.
// Depends on idt_pkg.
module idt_queue import idt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   input  logic     pop,
   output logic     not_empty,
   output logic     has_room,
   output pair_type head
);
   pair_type mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign not_empty = (cnt_ff != 3'd0);
   // Room while fewer than four pairs are held; the front steps against the registered count.
   assign has_room  = (cnt_ff < 3'd4);
   assign head      = mem_ff[rd_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

/* rtl/core/idt_back.sv */
// Back part: unpacks result pairs into single items on the result channel.
// Depends on idt_pkg; reads from idt_queue.
module idt_back import idt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  pair_type q_head,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);
   logic second_ff, second_in;

   assign rsp_valid = q_valid;
   assign rsp_data  = (second_ff || !q_head.two) ?
                      (second_ff ? q_head.second : q_head.first) : q_head.first;

   // Pop after the last result of the pair leaves.
   always_comb begin
      second_in = second_ff;
      q_pop = 1'b0;
      if (q_valid && rsp_ready) begin
         if (q_head.two && !second_ff) second_in = 1'b1;
         else begin
            second_in = 1'b0;
            q_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) second_ff <= 1'b0;
      else second_ff <= second_in;
   end
endmodule

/* rtl/core/interface_definition_tokenizer_unit.sv */
// Tokenizer unit for an interface-definition language.
// Channels: req_ (one source byte or end marker per item), rsp_ (one token
// or error per item), csr_ (writes tab_width). All use valid/ready.
// One input byte is taken per cycle while the result queue has room; each
// byte gives zero, one or two results, which are registered in the queue
// and appear on rsp_ behind older results, two of one byte one after the
// other. Sustained input rate is one byte per cycle with queue room, set by
// the scanner state register; output is one result per cycle on rsp_ready.
// The front scanner feeds a four-entry queue of result pairs; when the
// receiver stalls the queue fills and req_ready drops, so no result is lost.
// Synchronous reset returns the scanner to line 1, column 1, offset 0, empties
// the queue and sets tab_width to 4. An end marker always gives an end token
// and rearms the scanner without touching tab_width.
`include "interface_definition_tokenizer_unit_assert.svh"
module interface_definition_tokenizer_unit import idt_pkg::*; #(
   parameter int LINE_WIDTH   = LineWidthDefault,
   parameter int COLUMN_WIDTH = ColumnWidthDefault,
   parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);
   logic [3:0] tab_ff;
   logic       step, push, q_valid, q_room, q_pop;
   pair_type   pair, head;

   assign req_ready = q_room;
   assign step      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Tab width register.
   always_ff @(posedge clock) begin
      if (reset) tab_ff <= TabWidthReset;
      else if (csr_valid) tab_ff <= csr_data;
   end

   idt_front #(
      .LINE_WIDTH(LINE_WIDTH), .COLUMN_WIDTH(COLUMN_WIDTH), .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_front (
      .clock(clock), .reset(reset), .step(step), .item(req_data),
      .tab_width(tab_ff), .push(push), .pair(pair)
   );

   idt_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(pair), .pop(q_pop),
      .not_empty(q_valid), .has_room(q_room), .head(head)
   );

   idt_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_head(head), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Checks.
   `IDT_ASSERT_IMPL(a_no_push_full, clock, reset, !(push && !q_room), "push into full queue")
   `IDT_ASSERT_IMPL(a_pop_valid, clock, reset, !(q_pop && !q_valid), "pop from empty queue")
   `IDT_ASSERT_NEXT(a_end_last, clock, reset, step && req_data.end_of_input, rsp_valid, "end marker gave no result")
endmodule

/* verif/interface_definition_tokenizer_unit_test.sv */
// Self-checking testbench for the tokenizer unit: directed rows, then random
// source streams, checked against an in-bench token predictor.
// Depends on idt_pkg and the RTL top level interface_definition_tokenizer_unit.
`timescale 1ns / 100ps
module interface_definition_tokenizer_unit_test;
   import idt_pkg::*;

   localparam int LineMax   = (1 << 20) - 1;
   localparam int ColumnMax = (1 << 16) - 1;
   localparam int OffsetMax = (1 << 24) - 1;
   localparam int RandomItems = 1250;
   localparam int CycleLimit = 400000;

   // Stimulus table entry; check_first set means the first result is typed in.
   typedef struct {
      req_type item;
      bit      check_first;
      rsp_type first;
   } row_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [3:0] csr_data = '0;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   rsp_type     token_queue[$];
   row_type     rows[$];

   // Predictor state.
   mode_type    scan_mode;
   logic [3:0]  tab_width;
   int unsigned line_count, column_count, byte_offset;
   int unsigned start_line, start_column, start_offset, length_count;

   interface_definition_tokenizer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned sat(int unsigned v, int unsigned inc, int unsigned max);
      longint unsigned r;
      r = longint'(v) + inc;
      return (r > max) ? max : 32'(r);
   endfunction

   function automatic bit byte_punct(logic [7:0] b);
      return b == "{" || b == "}" || b == "(" || b == ")" || b == "[" || b == "]" ||
             b == "<" || b == ">" || b == "*" || b == "," || b == ";" || b == "=";
   endfunction
   function automatic bit byte_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction
   function automatic bit byte_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic void rearm_scanner();
      scan_mode = MODE_IDLE;
      line_count = 1; column_count = 1; byte_offset = 0;
      start_line = 1; start_column = 1; start_offset = 0; length_count = 0;
   endfunction

   function automatic rsp_type make_token(kind_type k, int unsigned ln, int unsigned col,
                                          int unsigned off, int unsigned len,
                                          logic [7:0] ch);
      rsp_type t;
      t.token_kind = k; t.start_line = 20'(ln); t.start_column = 16'(col);
      t.start_offset = 24'(off); t.token_length = 24'(len); t.char_value = ch;
      t.last_of_run = 0;
      return t;
   endfunction

   function automatic void push_open(ref rsp_type res[$], input kind_type k,
                                     input logic [7:0] ch);
      res.push_back(make_token(k, start_line, start_column, start_offset,
                               length_count, ch));
   endfunction

   function automatic void mark(int unsigned len, mode_type m);
      start_line = line_count; start_column = column_count;
      start_offset = byte_offset; length_count = len; scan_mode = m;
   endfunction

   // Byte seen between tokens.
   function automatic void scan_idle(logic [7:0] b, ref rsp_type res[$]);
      if (b inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h08, 8'h0B}) scan_mode = MODE_IDLE;
      else if (b == "/") mark(1, MODE_SLASH);
      else if (byte_punct(b)) begin
         res.push_back(make_token(KIND_PUNCT, line_count, column_count, byte_offset, 1, b));
         scan_mode = MODE_IDLE;
      end else if (byte_alpha(b) || b == "_") mark(1, MODE_IDENT);
      else if (b == "0") mark(1, MODE_ZERO);
      else if (byte_digit(b)) mark(1, MODE_INTEGER);
      else if (b == 8'h22) mark(1, MODE_STRING);
      else begin
         res.push_back(make_token(KIND_BAD, line_count, column_count, byte_offset, 1, b));
         scan_mode = MODE_ERROR;
      end
   endfunction

   // Works out the tokens caused by one input item and updates the scanner.
   function automatic void predict_tokens(req_type it, ref rsp_type res[$]);
      logic [7:0] b;
      b = it.in_byte;
      res = {};
      if (it.end_of_input) begin
         case (scan_mode)
            MODE_SLASH: push_open(res, KIND_BAD, "/");
            MODE_BLOCK, MODE_BLOCK_STAR: push_open(res, KIND_OPEN_CM, 0);
            MODE_IDENT: push_open(res, KIND_IDENT, 0);
            MODE_ZERO, MODE_INTEGER: push_open(res, KIND_INTEGER, 0);
            MODE_STRING: push_open(res, KIND_OPEN_ST, 0);
            default: ;
         endcase
         res.push_back(make_token(KIND_END, line_count, column_count, byte_offset, 0, 0));
         rearm_scanner();
      end else begin
         case (scan_mode)
            MODE_SLASH:
               if (b == "/") scan_mode = MODE_LINE;
               else if (b == "*") begin
                  length_count = sat(length_count, 1, OffsetMax); scan_mode = MODE_BLOCK;
               end else begin
                  push_open(res, KIND_BAD, "/"); scan_mode = MODE_ERROR;
               end
            MODE_LINE: if (b == 8'h0A) scan_mode = MODE_IDLE;
            MODE_BLOCK: begin
               length_count = sat(length_count, 1, OffsetMax);
               if (b == "*") scan_mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               length_count = sat(length_count, 1, OffsetMax);
               if (b == "/") scan_mode = MODE_IDLE;
               else if (b != "*") scan_mode = MODE_BLOCK;
            end
            MODE_IDENT:
               if (byte_alpha(b) || byte_digit(b) || b == "_")
                  length_count = sat(length_count, 1, OffsetMax);
               else begin
                  push_open(res, KIND_IDENT, 0); scan_idle(b, res);
               end
            MODE_ZERO:
               if (b == "x" || b == "X") begin
                  length_count = sat(length_count, 1, OffsetMax); scan_mode = MODE_IDENT;
               end else if (byte_digit(b)) begin
                  length_count = sat(length_count, 1, OffsetMax); scan_mode = MODE_INTEGER;
               end else begin
                  push_open(res, KIND_INTEGER, 0); scan_idle(b, res);
               end
            MODE_INTEGER:
               if (byte_digit(b)) length_count = sat(length_count, 1, OffsetMax);
               else begin
                  push_open(res, KIND_INTEGER, 0); scan_idle(b, res);
               end
            MODE_STRING:
               if (b == 8'h22) begin
                  length_count = sat(length_count, 1, OffsetMax);
                  push_open(res, KIND_STRING, 0); scan_mode = MODE_IDLE;
               end else if (b == 8'h0A) begin
                  push_open(res, KIND_OPEN_ST, 0); scan_mode = MODE_ERROR;
               end else length_count = sat(length_count, 1, OffsetMax);
            MODE_ERROR: ;
            default: scan_idle(b, res);
         endcase
         // Position moves on after every byte.
         if (b == 8'h0A) begin
            line_count = sat(line_count, 1, LineMax); column_count = 1;
         end else if (b == 8'h09) column_count = sat(column_count, tab_width, ColumnMax);
         else if (!(b inside {8'h0D, 8'h08, 8'h0B}))
            column_count = sat(column_count, 1, ColumnMax);
         byte_offset = sat(byte_offset, 1, OffsetMax);
      end
      if (res.size() > 0) res[res.size() - 1].last_of_run = 1;
   endfunction

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stall per item, compare with the oldest expectation.
   initial begin : receive_tokens
      int unsigned gap;
      rsp_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(3) == 0 ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (token_queue.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = token_queue.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: token mismatch, expected %p, actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   task automatic write_tab(logic [3:0] w);
      csr_valid <= 1; csr_data <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      tab_width = w;
   endtask

   // Sends one item and queues its predicted tokens; a typed-in first token is
   // checked against the predictor too. Valid stays high after acceptance until
   // the next item or the caller drops it.
   task automatic send_item(req_type it, bit check_first, rsp_type typed, bit no_gap);
      rsp_type res[$];
      int unsigned gap;
      gap = no_gap ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tokens(it, res);
      if (check_first && (res.size() == 0 || res[0] !== typed)) begin
         $display("%0t: typed-in token mismatch, expected %p, actual %p", $time, typed,
                  res.size() ? res[0] : '0);
         error_count++;
      end
      foreach (res[i]) token_queue.push_back(res[i]);
   endtask

   task automatic wait_idle();
      while (token_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type bytev(logic [7:0] b);
      req_type r;
      r.in_byte = b; r.end_of_input = 0;
      return r;
   endfunction

   function automatic void add_row(logic [7:0] b, bit eoi, bit chk, rsp_type t);
      row_type r;
      r.item.in_byte = b; r.item.end_of_input = eoi; r.check_first = chk; r.first = t;
      rows.push_back(r);
   endfunction

   function automatic logic [7:0] pick_ws();
      logic [7:0] ws[$];
      ws = {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h08, 8'h0B};
      return ws[$urandom_range(ws.size() - 1)];
   endfunction

   // Picks a byte from a spread that favours well-formed source.
   function automatic logic [7:0] pick_byte();
      int unsigned k;
      logic [7:0] sym[$];
      sym = {"{", "}", "(", ")", "[", "]", "<", ">", "*", ",", ";", "=", "/", 8'h22};
      k = $urandom_range(0, 99);
      if (k < 30) begin
         if ($urandom_range(1)) return 8'("a" + $urandom_range(25));
         return 8'("A" + $urandom_range(25));
      end
      if (k < 42) return 8'("0" + $urandom_range(9));
      if (k < 60) return sym[$urandom_range(sym.size() - 1)];
      if (k < 75) return pick_ws();
      if (k < 80) return $urandom_range(1) ? "x" : "_";
      if (k < 85) return "0";
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin : drive_source
      int unsigned sent;
      int unsigned run_len;
      logic [3:0] tabs[$];
      string text;
      tabs = {4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
      rearm_scanner();
      tab_width = TabWidthReset;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed rows: reset position, punctuation, bad bytes, and the
      // constructs left open by the end marker.
      add_row("{", 0, 1, make_token(KIND_PUNCT, 1, 1, 0, 1, "{") | rsp_type'(1));
      add_row(8'h00, 0, 1, make_token(KIND_BAD, 1, 2, 1, 1, 8'h00) | rsp_type'(1));
      add_row(8'hFF, 0, 0, '0);
      add_row(0, 1, 1, make_token(KIND_END, 1, 4, 3, 0, 0) | rsp_type'(1));
      text = "\t0x_A9 007 0 \"s t\"/*a**/ //c\n/ ;\"q\n";
      foreach (text[i]) add_row(text[i], 0, 0, '0);
      add_row(0, 1, 0, '0);
      text = "/*x";
      foreach (text[i]) add_row(text[i], 0, 0, '0);
      add_row(0, 1, 0, '0);
      add_row("/", 0, 0, '0);
      add_row(0, 1, 1, make_token(KIND_BAD, 1, 1, 0, 1, "/"));
      foreach (rows[i]) send_item(rows[i].item, rows[i].check_first, rows[i].first, 0);
      req_valid <= 0;
      wait_idle();

      // Random streams, one tab setting per phase; back-to-back runs too.
      sent = 0;
      foreach (tabs[p]) begin
         write_tab(tabs[p]);
         while (sent < (p + 1) * RandomItems / tabs.size()) begin
            req_type it;
            run_len = $urandom_range(0, 4) == 0;
            it = bytev(pick_byte());
            if ($urandom_range(0, 39) == 0) it.end_of_input = 1;
            it.in_byte = it.end_of_input ? 8'($urandom_range(0, 255)) : it.in_byte;
            send_item(it, 0, '0, run_len);
            sent++;
         end
         send_item(bytev(0) | req_type'(1), 0, '0, 0);
         req_valid <= 0;
         wait_idle();
      end
      write_tab(4'd8);
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && token_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/idt_pkg.sv
rtl/core/idt_front.sv
rtl/core/idt_queue.sv
rtl/core/idt_back.sv
rtl/core/interface_definition_tokenizer_unit.sv
verif/interface_definition_tokenizer_unit_test.sv
